### rtl/irblt_pkg.sv
`default_nettype none

package irblt_pkg;

    // Default number of emitter pins that the block drives.
    localparam int unsigned NUM_EMITTERS_DEFAULT = 8;

    // Fixed field widths.
    localparam int unsigned LEVELS_W = 8;
    localparam int unsigned EMIT_W   = 3;
    localparam int unsigned TICK_W   = 12;
    localparam int unsigned TOG_W    = 10;
    localparam int unsigned HALF_W   = 8;
    localparam int unsigned CFG_W    = 12;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned S_DATA_W = 16;
    localparam int unsigned M_DATA_W = 16;

    // Kind of an input beat, carried in s_tuser.
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_OFFER = 1'b1;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_CARRIER_HIGH = 3'd0,
        REG_CARRIER_LOW  = 3'd1,
        REG_TAIL_HIGH    = 3'd2,
        REG_SPACE        = 3'd3,
        REG_START_TOG    = 3'd4,
        REG_ONE_TOG      = 3'd5,
        REG_ZERO_TOG     = 3'd6,
        REG_ENABLES      = 3'd7
    } cfg_idx_t;

    // Waveform phases: start burst and data bit burst segments.
    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_ST_CAR   = 3'd1,
        PH_ST_TAIL  = 3'd2,
        PH_ST_SPACE = 3'd3,
        PH_BT_CAR   = 3'd4,
        PH_BT_TAIL  = 3'd5,
        PH_BT_SPACE = 3'd6
    } phase_t;

    typedef struct packed {
        logic [HALF_W-1:0]   carrier_high_ticks;
        logic [HALF_W-1:0]   carrier_low_ticks;
        logic [HALF_W-1:0]   tail_high_ticks;
        logic [TICK_W-1:0]   space_ticks;
        logic [TOG_W-1:0]    start_toggles;
        logic [TOG_W-1:0]    one_toggles;
        logic [TOG_W-1:0]    zero_toggles;
        logic [LEVELS_W-1:0] enabled_emitters;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        carrier_high_ticks: 8'd5,
        carrier_low_ticks:  8'd11,
        tail_high_ticks:    8'd6,
        space_ticks:        12'd639,
        start_toggles:      10'd262,
        one_toggles:        10'd131,
        zero_toggles:       10'd64,
        enabled_emitters:   8'h00
    };

    typedef struct packed {
        logic              action;
        logic [7:0]        data_byte;
        logic              with_start;
        logic [EMIT_W-1:0] emitter;
    } item_t;

    typedef struct packed {
        logic [LEVELS_W-1:0] emitter_levels;
        logic                busy_res;
        logic                accepted;
        logic                byte_done;
    } result_t;

endpackage

`default_nettype wire

### rtl/irblt_core.sv
`default_nettype none

module irblt_core #(
    parameter int unsigned NUM_EMITTERS = irblt_pkg::NUM_EMITTERS_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              item_valid,
    input  wire irblt_pkg::item_t  item,
    input  wire irblt_pkg::cfg_t   cfg,
    output irblt_pkg::result_t     result
);

    // Waveform state.
    irblt_pkg::phase_t                phase_reg, phase_next;
    logic                             level_reg, level_next;
    logic [irblt_pkg::TOG_W-1:0]      tog_reg, tog_next;
    logic [irblt_pkg::TICK_W-1:0]     tick_reg, tick_next;
    logic [2:0]                       bit_reg, bit_next;
    logic [7:0]                       shift_reg, shift_next;
    logic [irblt_pkg::EMIT_W-1:0]     em_reg, em_next;

    // Holding register for the next byte.
    logic                             hold_valid_reg, hold_valid_next;
    logic [7:0]                       hold_data_reg, hold_data_next;
    logic                             hold_ws_reg, hold_ws_next;
    logic [irblt_pkg::EMIT_W-1:0]     hold_em_reg, hold_em_next;

    // State after a possible load from the holding register.
    logic                             is_tick, is_offer, load;
    irblt_pkg::phase_t                ph_a;
    logic                             lvl_a;
    logic [irblt_pkg::TOG_W-1:0]      tog_a;
    logic [irblt_pkg::TICK_W-1:0]     tick_a;
    logic [2:0]                       bit_a;
    logic [7:0]                       shift_a;
    logic [irblt_pkg::EMIT_W-1:0]     em_a;

    logic                             busy, is_start, in_car, in_tail, in_space;
    logic [irblt_pkg::TICK_W-1:0]     tick_inc;
    logic [irblt_pkg::HALF_W-1:0]     dur, dur_eff;
    logic [irblt_pkg::TOG_W-1:0]      tog_inc, target, target_eff;
    logic                             car_flip, car_end, tail_end, space_end;
    logic                             to_space, to_after, last_bit;
    logic                             offer_ok, pin_level;

    assign is_tick  = item_valid && (item.action == irblt_pkg::ACT_TICK);
    assign is_offer = item_valid && (item.action == irblt_pkg::ACT_OFFER);
    assign load     = is_tick && (phase_reg == irblt_pkg::PH_IDLE) && hold_valid_reg;

    // An idle tick with a held byte starts that byte at once.
    always_comb begin
        if (load) begin
            ph_a    = hold_ws_reg ? irblt_pkg::PH_ST_CAR : irblt_pkg::PH_BT_CAR;
            lvl_a   = 1'b1;
            tog_a   = '0;
            tick_a  = '0;
            bit_a   = '0;
            shift_a = hold_data_reg;
            em_a    = hold_em_reg;
        end else begin
            ph_a    = phase_reg;
            lvl_a   = level_reg;
            tog_a   = tog_reg;
            tick_a  = tick_reg;
            bit_a   = bit_reg;
            shift_a = shift_reg;
            em_a    = em_reg;
        end
    end

    // Segment end detection.
    assign busy     = (ph_a != irblt_pkg::PH_IDLE);
    assign is_start = (ph_a == irblt_pkg::PH_ST_CAR) || (ph_a == irblt_pkg::PH_ST_TAIL)
                   || (ph_a == irblt_pkg::PH_ST_SPACE);
    assign in_car   = (ph_a == irblt_pkg::PH_ST_CAR) || (ph_a == irblt_pkg::PH_BT_CAR);
    assign in_tail  = (ph_a == irblt_pkg::PH_ST_TAIL) || (ph_a == irblt_pkg::PH_BT_TAIL);
    assign in_space = (ph_a == irblt_pkg::PH_ST_SPACE) || (ph_a == irblt_pkg::PH_BT_SPACE);

    assign tick_inc = tick_a + 1'b1;
    assign dur      = lvl_a ? cfg.carrier_high_ticks : cfg.carrier_low_ticks;
    assign dur_eff  = (dur == '0) ? irblt_pkg::HALF_W'(1) : dur;
    assign car_flip = in_car && (tick_inc >= {4'b0, dur_eff});

    assign tog_inc    = tog_a + 1'b1;
    assign target     = is_start ? cfg.start_toggles
                      : (shift_a[bit_a] ? cfg.one_toggles : cfg.zero_toggles);
    assign target_eff = (target == '0) ? irblt_pkg::TOG_W'(1) : target;
    assign car_end    = car_flip && (tog_inc >= target_eff);

    assign tail_end  = in_tail && (tick_inc >= {4'b0, cfg.tail_high_ticks});
    assign space_end = in_space && (tick_inc >= cfg.space_ticks);

    // Empty tail and space segments fall straight through.
    assign to_space = (car_end && (cfg.tail_high_ticks == '0)) || tail_end;
    assign to_after = (to_space && (cfg.space_ticks == '0)) || space_end;
    assign last_bit = !is_start && (bit_a == 3'd7);

    assign offer_ok = !hold_valid_reg && ({1'b0, item.emitter} < 4'(NUM_EMITTERS))
                   && cfg.enabled_emitters[item.emitter];

    // Next state.
    always_comb begin
        phase_next      = phase_reg;
        level_next      = level_reg;
        tog_next        = tog_reg;
        tick_next       = tick_reg;
        bit_next        = bit_reg;
        shift_next      = shift_reg;
        em_next         = em_reg;
        hold_valid_next = hold_valid_reg;
        hold_data_next  = hold_data_reg;
        hold_ws_next    = hold_ws_reg;
        hold_em_next    = hold_em_reg;

        if (is_offer && offer_ok) begin
            hold_valid_next = 1'b1;
            hold_data_next  = item.data_byte;
            hold_ws_next    = item.with_start;
            hold_em_next    = item.emitter;
        end

        if (is_tick) begin
            if (load) begin
                hold_valid_next = 1'b0;
            end
            phase_next = ph_a;
            level_next = lvl_a;
            tog_next   = tog_a;
            tick_next  = tick_a;
            bit_next   = bit_a;
            shift_next = shift_a;
            em_next    = em_a;

            if (busy) begin
                tick_next = tick_inc;
                if (car_flip) begin
                    tick_next  = '0;
                    level_next = ~lvl_a;
                    tog_next   = tog_inc;
                end
                if (car_end && (cfg.tail_high_ticks != '0)) begin
                    phase_next = is_start ? irblt_pkg::PH_ST_TAIL : irblt_pkg::PH_BT_TAIL;
                    tick_next  = '0;
                end
                if (to_space && (cfg.space_ticks != '0)) begin
                    phase_next = is_start ? irblt_pkg::PH_ST_SPACE : irblt_pkg::PH_BT_SPACE;
                    tick_next  = '0;
                end
                if (to_after) begin
                    tick_next = '0;
                    tog_next  = '0;
                    if (last_bit) begin
                        phase_next = irblt_pkg::PH_IDLE;
                        level_next = 1'b0;
                        bit_next   = '0;
                    end else begin
                        phase_next = irblt_pkg::PH_BT_CAR;
                        level_next = 1'b1;
                        bit_next   = is_start ? 3'd0 : bit_a + 3'd1;
                    end
                end
            end
        end
    end

    // Result of the beat.
    always_comb begin
        case (ph_a)
            irblt_pkg::PH_ST_CAR,
            irblt_pkg::PH_BT_CAR:   pin_level = lvl_a;
            irblt_pkg::PH_ST_TAIL,
            irblt_pkg::PH_BT_TAIL:  pin_level = 1'b1;
            default:                pin_level = 1'b0;
        endcase

        result.emitter_levels = '0;
        if (pin_level && ({1'b0, em_a} < 4'(NUM_EMITTERS))) begin
            result.emitter_levels = irblt_pkg::LEVELS_W'(1) << em_a;
        end
        result.busy_res  = busy;
        result.accepted  = is_offer && offer_ok;
        result.byte_done = is_tick && busy && to_after && last_bit;
    end

    // Control state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= irblt_pkg::PH_IDLE;
            level_reg      <= 1'b0;
            tog_reg        <= '0;
            tick_reg       <= '0;
            bit_reg        <= '0;
            em_reg         <= '0;
            hold_valid_reg <= 1'b0;
        end else if (item_valid) begin
            phase_reg      <= phase_next;
            level_reg      <= level_next;
            tog_reg        <= tog_next;
            tick_reg       <= tick_next;
            bit_reg        <= bit_next;
            em_reg         <= em_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Byte payload.
    always_ff @(posedge aclk) begin
        if (item_valid) begin
            shift_reg     <= shift_next;
            hold_data_reg <= hold_data_next;
            hold_ws_reg   <= hold_ws_next;
            hold_em_reg   <= hold_em_next;
        end
    end

endmodule

`default_nettype wire

### rtl/ir_burst_length_byte_transmitter_unit.sv
// IR burst-length byte transmitter. Each input beat is either a one
// microsecond tick (s_tuser = 0) or a byte offer (s_tuser = 1); every beat
// gives exactly one result beat with the emitter pin levels, the busy flag,
// whether the offer was taken and whether this tick finished a byte. The block
// takes one beat per clock cycle: the waveform state advances in a single
// registered step, and each result passes an output register backed by a
// one-beat skid stage, so s_tready drops only when two results wait unread.
// Registers are written through the cfg_* port, one index per register; the
// user writes them only while no beat is in flight, unenforced by the block.
`default_nettype none

module ir_burst_length_byte_transmitter_unit #(
    parameter int unsigned NUM_EMITTERS = irblt_pkg::NUM_EMITTERS_DEFAULT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Input beats.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // s_tdata: data_byte [7:0], with_start [8], emitter [11:9], zero [15:12].
    input  wire logic [irblt_pkg::S_DATA_W-1:0]   s_tdata,
    // s_tuser: action [0].
    input  wire logic                             s_tuser,
    // Result beats.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // m_tdata: emitter_levels [7:0], busy_res [8], accepted [9], byte_done [10].
    output logic [irblt_pkg::M_DATA_W-1:0]        m_tdata,
    // Register writes.
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [irblt_pkg::IDX_W-1:0]      cfg_index,
    input  wire logic [irblt_pkg::CFG_W-1:0]      cfg_data
);

    irblt_pkg::cfg_t    cfg_reg;
    irblt_pkg::item_t   item;
    irblt_pkg::result_t result;
    irblt_pkg::result_t out_reg, skid_reg;
    logic               out_valid_reg, skid_valid_reg;
    logic               s_accept, m_pop;

    assign cfg_ready = 1'b1;

    // Register file.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= irblt_pkg::CFG_RESET;
        end else if (cfg_valid) begin
            case (irblt_pkg::cfg_idx_t'(cfg_index))
                irblt_pkg::REG_CARRIER_HIGH: cfg_reg.carrier_high_ticks <= cfg_data[7:0];
                irblt_pkg::REG_CARRIER_LOW:  cfg_reg.carrier_low_ticks  <= cfg_data[7:0];
                irblt_pkg::REG_TAIL_HIGH:    cfg_reg.tail_high_ticks    <= cfg_data[7:0];
                irblt_pkg::REG_SPACE:        cfg_reg.space_ticks        <= cfg_data;
                irblt_pkg::REG_START_TOG:    cfg_reg.start_toggles      <= cfg_data[9:0];
                irblt_pkg::REG_ONE_TOG:      cfg_reg.one_toggles        <= cfg_data[9:0];
                irblt_pkg::REG_ZERO_TOG:     cfg_reg.zero_toggles       <= cfg_data[9:0];
                irblt_pkg::REG_ENABLES:      cfg_reg.enabled_emitters   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Unpack the input beat.
    assign item.action     = s_tuser;
    assign item.data_byte  = s_tdata[7:0];
    assign item.with_start = s_tdata[8];
    assign item.emitter    = s_tdata[11:9];

    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign m_pop    = out_valid_reg && m_tready;

    irblt_core #(
        .NUM_EMITTERS (NUM_EMITTERS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (s_accept),
        .item       (item),
        .cfg        (cfg_reg),
        .result     (result)
    );

    // Output register and skid stage valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (s_accept) begin
            if (out_valid_reg && !m_pop) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (m_pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register and skid stage payload.
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_pop) begin
                out_reg <= skid_reg;
            end
        end else if (s_accept) begin
            if (out_valid_reg && !m_pop) begin
                skid_reg <= result;
            end else begin
                out_reg <= result;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_reg.byte_done, out_reg.accepted, out_reg.busy_res,
                       out_reg.emitter_levels};

endmodule

`default_nettype wire

### rtl/irblt_checker.sv
`default_nettype none

module irblt_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [irblt_pkg::M_DATA_W-1:0] m_tdata
);

    // At most one emitter pin is driven high.
    a_one_pin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0(m_tdata[7:0]))
        else $error("more than one emitter pin high");

    // A driven pin implies a burst in progress.
    a_pin_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[7:0] != 8'h00)) |-> m_tdata[8])
        else $error("emitter pin high while idle");

    // An offer result never ends a byte.
    a_acc_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[9] && m_tdata[10]))
        else $error("accepted and byte_done in one beat");

    // Backpressure on the input only with a result waiting.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // A stalled result beat holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result beat changed");

endmodule

bind ir_burst_length_byte_transmitter_unit irblt_checker u_irblt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
